// ===== rtl/csc_pkg.sv =====
package csc_pkg;

    localparam int RAW_P_W = 20;
    localparam int RAW_T_W = 20;
    localparam int RAW_H_W = 16;
    localparam int TEMP_W  = 15;
    localparam int PRESS_W = 17;
    localparam int HUM_W   = 17;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;
    localparam int DIV_W = 32;

    // fixed latencies of the datapath units, in enabled cycles
    localparam int TEMP_LAT  = 5;
    localparam int PRESS_LAT = 7 + DIV_W + 4;
    localparam int HUM_LAT   = 8;

    localparam logic [RAW_T_W-1:0] TEMP_OFF_RAW  = 20'h80000;
    localparam logic [RAW_P_W-1:0] PRESS_OFF_RAW = 20'h80000;
    localparam logic [RAW_H_W-1:0] HUM_OFF_RAW   = 16'h8000;

    localparam logic signed [31:0] TEMP_MIN    = -32'sd4000;
    localparam logic signed [31:0] TEMP_MAX    = 32'sd8500;
    localparam logic [31:0]        PRESS_MIN   = 32'd30000;
    localparam logic [31:0]        PRESS_MAX   = 32'd110000;
    localparam logic signed [31:0] HUM_VAR_MAX = 32'sd419430400;
    localparam logic [31:0]        HUM_MAX     = 32'd102400;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CAL_TEMP       = 3'd0,
        REG_CAL_PRESS_LOW  = 3'd1,
        REG_CAL_PRESS_MID  = 3'd2,
        REG_CAL_PRESS_HIGH = 3'd3,
        REG_CAL_HUM_LOW    = 3'd4,
        REG_CAL_HUM_HIGH   = 3'd5
    } cfg_reg_t;

    // signed divide by 2**k, truncating toward zero
    function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] x,
                                                   input int unsigned k);
        logic signed [31:0] bias;
        bias = '0;
        if (x[31]) begin
            bias = (32'sd1 <<< k) - 32'sd1;
        end
        return (x + bias) >>> k;
    endfunction

    function automatic logic signed [31:0] ext_s16(input logic [15:0] v);
        return signed'({{16{v[15]}}, v});
    endfunction

    function automatic logic signed [31:0] ext_u16(input logic [15:0] v);
        return signed'({16'b0, v});
    endfunction

    function automatic logic signed [31:0] ext_s8(input logic [7:0] v);
        return signed'({{24{v[7]}}, v});
    endfunction

    function automatic logic signed [31:0] ext_u8(input logic [7:0] v);
        return signed'({24'b0, v});
    endfunction

endpackage

// ===== rtl/csc_delay.sv =====
module csc_delay
    import csc_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] stage_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                stage_reg[i] <= '0;
            end
        end else if (en) begin
            stage_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                stage_reg[i] <= stage_reg[i-1];
            end
        end
    end

    assign q = stage_reg[DEPTH-1];

endmodule

// ===== rtl/csc_div.sv =====
module csc_div
    import csc_pkg::*;
#(
    parameter int W      = DIV_W,
    parameter int SIDE_W = 2
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [W-1:0]      dividend,
    input  logic [W-1:0]      divisor,
    input  logic [SIDE_W-1:0] side_in,
    output logic [W-1:0]      quotient,
    output logic [SIDE_W-1:0] side_out
);

    // restoring divider, one quotient bit per stage; the dividend shifts
    // out of nq while quotient bits shift in
    logic [W-1:0]      rem_reg  [W];
    logic [W-1:0]      nq_reg   [W];
    logic [W-1:0]      d_reg    [W];
    logic [SIDE_W-1:0] side_reg [W];

    for (genvar i = 0; i < W; i++) begin : g_stage
        logic [W-1:0]      rem_in;
        logic [W-1:0]      nq_in;
        logic [W-1:0]      d_in;
        logic [SIDE_W-1:0] side_i;
        logic [W:0]        trial;
        logic [W:0]        diff;
        logic              take;

        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = dividend;
            assign d_in   = divisor;
            assign side_i = side_in;
        end else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign nq_in  = nq_reg[i-1];
            assign d_in   = d_reg[i-1];
            assign side_i = side_reg[i-1];
        end

        assign trial = {rem_in, nq_in[W-1]};
        assign diff  = trial - {1'b0, d_in};
        assign take  = trial >= {1'b0, d_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= take ? diff[W-1:0] : trial[W-1:0];
                nq_reg[i]   <= {nq_in[W-2:0], take};
                d_reg[i]    <= d_in;
                side_reg[i] <= side_i;
            end
        end
    end

    assign quotient = nq_reg[W-1];
    assign side_out = side_reg[W-1];

endmodule

// ===== rtl/csc_temp.sv =====
module csc_temp
    import csc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     en,
    input  logic [RAW_T_W-1:0]       raw_t,
    input  logic [47:0]              cal_temp,
    output logic signed [31:0]       fine,
    output logic [TEMP_W-1:0]        temp
);

    logic signed [31:0] t1, t2, t3;
    assign t1 = ext_u16(cal_temp[15:0]);
    assign t2 = ext_s16(cal_temp[31:16]);
    assign t3 = ext_s16(cal_temp[47:32]);

    logic signed [31:0] a0_reg, b0_reg, am_reg, bb_reg, a_reg, bm_reg;
    logic signed [31:0] fine_reg, fine_out_reg;
    logic [TEMP_W-1:0]  temp_reg;
    logic signed [31:0] tx, tc;

    always_comb begin
        tx = sdiv_p2((fine_reg <<< 2) + fine_reg + 32'sd128, 8);
        tc = tx;
        if (tx < TEMP_MIN) begin
            tc = TEMP_MIN;
        end else if (tx > TEMP_MAX) begin
            tc = TEMP_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a0_reg       <= signed'({15'b0, raw_t[19:3]}) - (t1 <<< 1);
            b0_reg       <= signed'({16'b0, raw_t[19:4]}) - t1;
            am_reg       <= a0_reg * t2;
            bb_reg       <= b0_reg * b0_reg;
            a_reg        <= sdiv_p2(am_reg, 11);
            bm_reg       <= sdiv_p2(bb_reg, 12) * t3;
            fine_reg     <= a_reg + sdiv_p2(bm_reg, 14);
            fine_out_reg <= fine_reg;
            temp_reg     <= tc[TEMP_W-1:0];
        end
    end

    assign fine = fine_out_reg;
    assign temp = temp_reg;

endmodule

// ===== rtl/csc_press.sv =====
module csc_press
    import csc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 en,
    input  logic [RAW_P_W-1:0]   raw_p,
    input  logic signed [31:0]   fine,
    input  logic [47:0]          cal_low,
    input  logic [47:0]          cal_mid,
    input  logic [47:0]          cal_high,
    output logic [PRESS_W-1:0]   pressure
);

    logic signed [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign p1 = ext_u16(cal_low[15:0]);
    assign p2 = ext_s16(cal_low[31:16]);
    assign p3 = ext_s16(cal_low[47:32]);
    assign p4 = ext_s16(cal_mid[15:0]);
    assign p5 = ext_s16(cal_mid[31:16]);
    assign p6 = ext_s16(cal_mid[47:32]);
    assign p7 = ext_s16(cal_high[15:0]);
    assign p8 = ext_s16(cal_high[31:16]);
    assign p9 = ext_s16(cal_high[47:32]);

    // offset and sensitivity terms
    logic signed [31:0] a1_reg, aq1_reg;
    logic signed [31:0] sq2_reg, ap5_reg, a2_reg;
    logic signed [31:0] b13_reg, ap5x2_3_reg, c3_reg, d3_reg;
    logic signed [31:0] b4_reg, x4_reg;
    logic signed [31:0] xm5_reg;
    logic [31:0]        pr5_reg;
    logic [31:0]        pm6_reg;
    logic signed [31:0] dv6_reg;
    logic [31:0]        num7_reg, den7_reg;
    logic [1:0]         side7_reg;
    logic [RAW_P_W-1:0] adc1_reg, adc2_reg, adc3_reg, adc4_reg;

    logic signed [31:0] a1_next, acd4, b4_next;

    always_comb begin
        a1_next = sdiv_p2(fine, 1) - 32'sd64000;
        acd4    = sdiv_p2(sdiv_p2(c3_reg, 3) + sdiv_p2(d3_reg, 1), 18);
        b4_next = sdiv_p2(b13_reg + ap5x2_3_reg, 2) + (p4 <<< 16);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg      <= a1_next;
            aq1_reg     <= sdiv_p2(a1_next, 2);
            adc1_reg    <= raw_p;

            sq2_reg     <= aq1_reg * aq1_reg;
            ap5_reg     <= a1_reg * p5;
            a2_reg      <= a1_reg;
            adc2_reg    <= adc1_reg;

            b13_reg     <= sdiv_p2(sq2_reg, 11) * p6;
            ap5x2_3_reg <= ap5_reg <<< 1;
            c3_reg      <= p3 * sdiv_p2(sq2_reg, 13);
            d3_reg      <= p2 * a2_reg;
            adc3_reg    <= adc2_reg;

            b4_reg      <= b4_next;
            x4_reg      <= 32'sd32768 + acd4;
            adc4_reg    <= adc3_reg;

            xm5_reg     <= x4_reg * p1;
            pr5_reg     <= (32'd1048576 - {12'b0, adc4_reg})
                           - unsigned'(sdiv_p2(b4_reg, 12));

            pm6_reg     <= pr5_reg * 32'd3125;
            dv6_reg     <= sdiv_p2(xm5_reg, 15);

            // upper half set: divide first, then double
            num7_reg    <= pm6_reg[31] ? pm6_reg : {pm6_reg[30:0], 1'b0};
            den7_reg    <= unsigned'(dv6_reg);
            side7_reg   <= {dv6_reg == 32'sd0, pm6_reg[31]};
        end
    end

    logic [31:0] q_div;
    logic [1:0]  side_div;

    csc_div #(
        .W      (DIV_W),
        .SIDE_W (2)
    ) u_div (
        .aclk     (aclk),
        .en       (en),
        .dividend (num7_reg),
        .divisor  (den7_reg),
        .side_in  (side7_reg),
        .quotient (q_div),
        .side_out (side_div)
    );

    logic [31:0]        p8_reg, p9_reg, p10_reg;
    logic               z8_reg, z9_reg, z10_reg;
    logic [31:0]        uu9_reg;
    logic signed [31:0] pm8_9_reg, am10_reg, bb10_reg;
    logic [PRESS_W-1:0] press_reg;

    logic [31:0]        u9;
    logic signed [31:0] s11;
    logic [31:0]        pf11, pc11;

    always_comb begin
        u9   = {3'b0, p8_reg[31:3]};
        s11  = sdiv_p2(sdiv_p2(am10_reg, 12) + bb10_reg + p7, 4);
        pf11 = p10_reg + unsigned'(s11);
        pc11 = pf11;
        if (z10_reg || pf11 < PRESS_MIN) begin
            pc11 = PRESS_MIN;
        end else if (pf11 > PRESS_MAX) begin
            pc11 = PRESS_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p8_reg    <= side_div[0] ? {q_div[30:0], 1'b0} : q_div;
            z8_reg    <= side_div[1];

            uu9_reg   <= u9 * u9;
            pm8_9_reg <= signed'({2'b0, p8_reg[31:2]}) * p8;
            p9_reg    <= p8_reg;
            z9_reg    <= z8_reg;

            am10_reg  <= p9 * signed'({13'b0, uu9_reg[31:13]});
            bb10_reg  <= sdiv_p2(pm8_9_reg, 13);
            p10_reg   <= p9_reg;
            z10_reg   <= z9_reg;

            press_reg <= pc11[PRESS_W-1:0];
        end
    end

    assign pressure = press_reg;

endmodule

// ===== rtl/csc_hum.sv =====
module csc_hum
    import csc_pkg::*;
(
    input  logic                aclk,
    input  logic                en,
    input  logic [RAW_H_W-1:0]  raw_h,
    input  logic signed [31:0]  fine,
    input  logic [31:0]         cal_low,
    input  logic [39:0]         cal_high,
    output logic [HUM_W-1:0]    humidity
);

    logic signed [31:0] h1, h2, h3, h4, h5, h6;
    assign h1 = ext_u8(cal_low[7:0]);
    assign h2 = ext_s16(cal_low[23:8]);
    assign h3 = ext_u8(cal_low[31:24]);
    assign h4 = ext_s16(cal_high[15:0]);
    assign h5 = ext_s16(cal_high[31:16]);
    assign h6 = ext_s8(cal_high[39:32]);

    logic signed [31:0] v1_1_reg, d_1_reg;
    logic signed [31:0] m5_2_reg, m6_2_reg, m3_2_reg, d_2_reg;
    logic signed [31:0] v5_3_reg, mm_3_reg;
    logic signed [31:0] v5_4_reg, mh2_4_reg;
    logic signed [31:0] v3_5_reg;
    logic signed [31:0] v3_6_reg, qq_6_reg;
    logic signed [31:0] v3_7_reg, m1_7_reg;
    logic [HUM_W-1:0]   hum_reg;

    logic signed [31:0] q6, v8, vc8;
    logic [31:0]        h8;

    always_comb begin
        q6  = sdiv_p2(v3_5_reg, 15);
        v8  = v3_7_reg - sdiv_p2(m1_7_reg, 4);
        vc8 = v8;
        if (v8 < 32'sd0) begin
            vc8 = '0;
        end
        if (vc8 > HUM_VAR_MAX) begin
            vc8 = HUM_VAR_MAX;
        end
        h8 = {12'b0, vc8[31:12]};
        if (h8 > HUM_MAX) begin
            h8 = HUM_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v1_1_reg  <= fine - 32'sd76800;
            d_1_reg   <= signed'({2'b0, raw_h, 14'b0}) - (h4 <<< 20);

            m5_2_reg  <= h5 * v1_1_reg;
            m6_2_reg  <= v1_1_reg * h6;
            m3_2_reg  <= v1_1_reg * h3;
            d_2_reg   <= d_1_reg;

            v5_3_reg  <= sdiv_p2(d_2_reg - m5_2_reg + 32'sd16384, 15);
            mm_3_reg  <= sdiv_p2(m6_2_reg, 10) * (sdiv_p2(m3_2_reg, 11) + 32'sd32768);

            v5_4_reg  <= v5_3_reg;
            mh2_4_reg <= (sdiv_p2(mm_3_reg, 10) + 32'sd2097152) * h2;

            v3_5_reg  <= v5_4_reg * sdiv_p2(mh2_4_reg + 32'sd8192, 14);

            v3_6_reg  <= v3_5_reg;
            qq_6_reg  <= q6 * q6;

            v3_7_reg  <= v3_6_reg;
            m1_7_reg  <= sdiv_p2(qq_6_reg, 7) * h1;

            hum_reg   <= h8[HUM_W-1:0];
        end
    end

    assign humidity = hum_reg;

endmodule

// ===== rtl/climate_sensor_compensation.sv =====
// Compensation of raw climate sensor samples into temperature, pressure and
// humidity using factory calibration coefficients.
// Input channel (s_*): one raw sample triple per transfer.
// Output channel (m_*): one compensated result per accepted sample, in order;
// m_tuser flags which channels carry a computed value (others read 0).
// Configuration channel (cfg_*): always ready; writes one calibration
// register per transfer and is meant to be used while the pipeline is empty.
// From input transfer to output valid, when not stalled, a sample passes
// through the temperature unit, the pressure unit (including the pipelined
// divider) and the output register. Humidity and temperature results are
// delayed to line up with pressure.
// Throughput: one sample per cycle unless the receiver stalls; the whole
// pipeline advances on one enable. When the receiver stalls, the pipeline
// freezes and s_tready drops in the same cycle, so nothing is lost or repeated.
// Reset clears the output valid flag, the flag pipeline and the calibration registers to zero.
module climate_sensor_compensation
    import csc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // raw_pressure[19:0], raw_temperature[39:20], raw_humidity[55:40]
    input  logic [55:0]           s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // temp_centideg[14:0], pressure_pa[31:15], humidity_q10[48:32]
    output logic [55:0]           m_tdata,
    // temp_valid[0], pressure_valid[1], humidity_valid[2]
    output logic [2:0]            m_tuser,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int TOTAL_LAT = TEMP_LAT + PRESS_LAT;

    logic [47:0] cal_temp_reg, cal_press_low_reg, cal_press_mid_reg, cal_press_high_reg;
    logic [31:0] cal_hum_low_reg;
    logic [39:0] cal_hum_high_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_temp_reg       <= '0;
            cal_press_low_reg  <= '0;
            cal_press_mid_reg  <= '0;
            cal_press_high_reg <= '0;
            cal_hum_low_reg    <= '0;
            cal_hum_high_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_CAL_TEMP:       cal_temp_reg       <= cfg_data;
                REG_CAL_PRESS_LOW:  cal_press_low_reg  <= cfg_data;
                REG_CAL_PRESS_MID:  cal_press_mid_reg  <= cfg_data;
                REG_CAL_PRESS_HIGH: cal_press_high_reg <= cfg_data;
                REG_CAL_HUM_LOW:    cal_hum_low_reg    <= cfg_data[31:0];
                REG_CAL_HUM_HIGH:   cal_hum_high_reg   <= cfg_data[39:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic m_tvalid_reg;
    logic [55:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    logic [RAW_P_W-1:0] raw_p;
    logic [RAW_T_W-1:0] raw_t;
    logic [RAW_H_W-1:0] raw_h;
    logic tv_in, pv_in, hv_in;

    assign raw_p = s_tdata[19:0];
    assign raw_t = s_tdata[39:20];
    assign raw_h = s_tdata[55:40];
    assign tv_in = raw_t != TEMP_OFF_RAW;
    assign pv_in = tv_in && (raw_p != PRESS_OFF_RAW);
    assign hv_in = tv_in && (raw_h != HUM_OFF_RAW);

    // transfer flag and channel flags ride along the full pipeline depth
    logic [3:0] flags_out;

    csc_delay #(.WIDTH(4), .DEPTH(TOTAL_LAT)) u_flags (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d       ({hv_in, pv_in, tv_in, s_tvalid}),
        .q       (flags_out)
    );

    logic signed [31:0] fine;
    logic [TEMP_W-1:0]  temp;

    csc_temp u_temp (
        .aclk     (aclk),
        .en       (en),
        .raw_t    (raw_t),
        .cal_temp (cal_temp_reg),
        .fine     (fine),
        .temp     (temp)
    );

    logic [RAW_P_W+RAW_H_W-1:0] raw_dly;

    csc_delay #(.WIDTH(RAW_P_W + RAW_H_W), .DEPTH(TEMP_LAT)) u_raw_dly (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d       ({raw_h, raw_p}),
        .q       (raw_dly)
    );

    logic [PRESS_W-1:0] pressure;
    logic [HUM_W-1:0]   humidity, humidity_dly;
    logic [TEMP_W-1:0]  temp_dly;

    csc_press u_press (
        .aclk     (aclk),
        .en       (en),
        .raw_p    (raw_dly[RAW_P_W-1:0]),
        .fine     (fine),
        .cal_low  (cal_press_low_reg),
        .cal_mid  (cal_press_mid_reg),
        .cal_high (cal_press_high_reg),
        .pressure (pressure)
    );

    csc_hum u_hum (
        .aclk     (aclk),
        .en       (en),
        .raw_h    (raw_dly[RAW_P_W+RAW_H_W-1:RAW_P_W]),
        .fine     (fine),
        .cal_low  (cal_hum_low_reg),
        .cal_high (cal_hum_high_reg),
        .humidity (humidity)
    );

    csc_delay #(.WIDTH(HUM_W), .DEPTH(PRESS_LAT - HUM_LAT)) u_hum_dly (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d       (humidity),
        .q       (humidity_dly)
    );

    csc_delay #(.WIDTH(TEMP_W), .DEPTH(PRESS_LAT)) u_temp_dly (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d       (temp),
        .q       (temp_dly)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= flags_out[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {7'b0,
                            flags_out[3] ? humidity_dly : {HUM_W{1'b0}},
                            flags_out[2] ? pressure     : {PRESS_W{1'b0}},
                            flags_out[1] ? temp_dly     : {TEMP_W{1'b0}}};
            m_tuser_reg <= flags_out[3:1];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_off_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("disabled temperature must give all-zero result");

    a_flag_dep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1] || m_tuser[2]) |-> m_tuser[0])
        else $error("pressure or humidity flagged without temperature");

    a_press_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |->
            m_tdata[31:15] >= 17'd30000 && m_tdata[31:15] <= 17'd110000)
        else $error("pressure out of clamp range");

    a_temp_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            $signed(m_tdata[14:0]) >= -15'sd4000 && $signed(m_tdata[14:0]) <= 15'sd8500)
        else $error("temperature out of clamp range");

    a_hum_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[48:32] <= 17'd102400)
        else $error("humidity out of clamp range");

endmodule

// ===== tb/tb.sv =====
module tb;
    import csc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 60;

    typedef struct packed {
        logic [15:0] hum;
        logic [19:0] temp;
        logic [19:0] press;
    } sample_t;

    typedef struct packed {
        logic [14:0] temp;
        logic [16:0] press;
        logic [16:0] hum;
        logic        tv;
        logic        pv;
        logic        hv;
    } reading_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    climate_sensor_compensation dut (.*);

    always #1 aclk = ~aclk;

    // calibration copy
    logic [47:0] k_temp, k_plo, k_pmid, k_phi;
    logic [31:0] k_hlo;
    logic [39:0] k_hhi;

    sample_t  sample_q[$];
    reading_t reading_q[$];
    int       errors = 0;
    int       sent = 0;
    int       got = 0;
    int       cycles = 0;
    int       cfg_writes = 0;
    bit       running = 0;
    bit       calm = 0;
    bit       in_taken = 0;
    bit       held = 0;
    int       hold_left = 0;

    function automatic reading_t compensate(sample_t s);
        reading_t r;
        int adc, fine, t, a, b, c, d, q, x, y, ps;
        int t1, p1, h1, h3, v1, v2, v3, v4, v5;
        shortint t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2, h4, h5;
        byte h6;
        int unsigned pu, ua, ub, u;
        r = '0;
        if (s.temp == TEMP_OFF_RAW) return r;
        t1 = int'(k_temp[15:0]); t2 = k_temp[31:16]; t3 = k_temp[47:32];
        adc = int'(s.temp);
        a = adc / 8 - t1 * 2;
        a = (a * t2) / 2048;
        b = adc / 16 - t1;
        b = ((b * b) / 4096 * t3) / 16384;
        fine = a + b;
        t = (fine * 5 + 128) / 256;
        if (t < -4000) t = -4000;
        else if (t > 8500) t = 8500;
        r.temp = t[14:0];
        r.tv = 1;
        if (s.press != PRESS_OFF_RAW) begin
            p1 = int'(k_plo[15:0]); p2 = k_plo[31:16]; p3 = k_plo[47:32];
            p4 = k_pmid[15:0]; p5 = k_pmid[31:16]; p6 = k_pmid[47:32];
            p7 = k_phi[15:0]; p8 = k_phi[31:16]; p9 = k_phi[47:32];
            a = fine / 2 - 64000;
            q = a / 4;
            b = ((q * q) / 2048) * p6;
            b = b + (a * p5) * 2;
            b = b / 4 + p4 * 65536;
            c = (p3 * ((q * q) / 8192)) / 8;
            d = (p2 * a) / 2;
            a = (c + d) / 262144;
            a = ((32768 + a) * p1) / 32768;
            r.pv = 1;
            if (a == 0) begin
                pu = PRESS_MIN;
            end else begin
                q = b / 4096;
                ub = q;
                ua = a;
                pu = ((32'd1048576 - {12'b0, s.press}) - ub) * 32'd3125;
                if (pu < 32'h80000000) pu = (pu * 2) / ua;
                else pu = (pu / ua) * 2;
                u = pu / 8;
                x = (u * u) / 8192;
                y = pu / 4;
                a = (p9 * x) / 4096;
                b = (y * p8) / 8192;
                ps = pu;
                ps = ps + ((a + b) + p7) / 16;
                pu = ps;
                if (pu < PRESS_MIN) pu = PRESS_MIN;
                else if (pu > PRESS_MAX) pu = PRESS_MAX;
            end
            r.press = pu[16:0];
        end
        if (s.hum != HUM_OFF_RAW) begin
            h1 = int'(k_hlo[7:0]); h2 = k_hlo[23:8]; h3 = int'(k_hlo[31:24]);
            h4 = k_hhi[15:0]; h5 = k_hhi[31:16]; h6 = k_hhi[39:32];
            adc = int'(s.hum);
            v1 = fine - 76800;
            v2 = adc * 16384;
            v3 = h4 * 1048576;
            v4 = h5 * v1;
            v5 = (v2 - v3 - v4 + 16384) / 32768;
            v2 = (v1 * h6) / 1024;
            v3 = (v1 * h3) / 2048;
            v4 = (v2 * (v3 + 32768)) / 1024 + 2097152;
            v2 = (v4 * h2 + 8192) / 16384;
            v3 = v5 * v2;
            v4 = ((v3 / 32768) * (v3 / 32768)) / 128;
            v5 = v3 - (v4 * h1) / 16;
            if (v5 < 0) v5 = 0;
            if (v5 > 419430400) v5 = 419430400;
            v5 = v5 / 4096;
            if (v5 > 102400) v5 = 102400;
            r.hum = v5[16:0];
            r.hv = 1;
        end
        return r;
    endfunction

    // input side: sample transfers and predictions
    always @(posedge aclk) begin
        in_taken <= s_tvalid && s_tready;
        if (s_tvalid && s_tready) begin
            reading_q.push_back(compensate(sample_t'(s_tdata)));
            sent++;
        end
    end

    always @(negedge aclk) begin
        if (running && (!s_tvalid || in_taken)) begin
            if (sample_q.size() > 0 && (calm || $urandom_range(0, 99) >= 9)) begin
                s_tdata <= sample_q.pop_front();
                s_tvalid <= 1;
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // output side: one long hold-off once the run is well underway
    always @(negedge aclk) begin
        if (!running) begin
            m_tready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 0;
        end else if (!held && got >= 500) begin
            held <= 1;
            hold_left <= 300;
            m_tready <= 0;
        end else begin
            m_tready <= calm || $urandom_range(0, 99) >= 9;
        end
    end

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        reading_t e;
        if (m_tvalid && m_tready) begin
            got++;
            if (reading_q.size() == 0) begin
                $error("result transfer with no sample pending");
                errors++;
            end else begin
                e = reading_q.pop_front();
                check_field("temp_centideg", int'(e.temp), int'(m_tdata[14:0]));
                check_field("pressure_pa", int'(e.press), int'(m_tdata[31:15]));
                check_field("humidity_q10", int'(e.hum), int'(m_tdata[48:32]));
                check_field("temp_valid", int'(e.tv), int'(m_tuser[0]));
                check_field("pressure_valid", int'(e.pv), int'(m_tuser[1]));
                check_field("humidity_valid", int'(e.hv), int'(m_tuser[2]));
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL climate_sensor_compensation");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [47:0] val);
        @(negedge aclk);
        cfg_valid <= 1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_CAL_TEMP:       k_temp = val;
            REG_CAL_PRESS_LOW:  k_plo = val;
            REG_CAL_PRESS_MID:  k_pmid = val;
            REG_CAL_PRESS_HIGH: k_phi = val;
            REG_CAL_HUM_LOW:    k_hlo = val[31:0];
            REG_CAL_HUM_HIGH:   k_hhi = val[39:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    function automatic logic [15:0] jit(int v, int span);
        return 16'(v + $urandom_range(0, 2 * span) - span);
    endfunction

    function automatic logic [47:0] rnd48();
        return 48'({$urandom(), $urandom()});
    endfunction

    task automatic load_cal(logic [47:0] c0, c1, c2, c3, c4, c5);
        write_reg(REG_CAL_TEMP, c0);
        write_reg(REG_CAL_PRESS_LOW, c1);
        write_reg(REG_CAL_PRESS_MID, c2);
        write_reg(REG_CAL_PRESS_HIGH, c3);
        write_reg(REG_CAL_HUM_LOW, c4);
        write_reg(REG_CAL_HUM_HIGH, c5);
        // indexes past the list must be ignored
        write_reg(3'd6, rnd48());
        write_reg(3'd7, rnd48());
    endtask

    // typical factory coefficients, optionally perturbed
    task automatic load_typical(int span, logic [15:0] p1);
        load_cal({jit(-1000, span), jit(26435, span), jit(27504, span)},
                 {jit(3024, span), jit(-10685, span), p1},
                 {jit(-7, span), jit(140, span), jit(2855, span)},
                 {jit(6000, span), jit(-14600, span), jit(15500, span)},
                 48'({8'(jit(0, span)), jit(362, span), 8'(jit(75, span))}),
                 48'({8'(jit(30, span)), jit(50, span), jit(313, span)}));
    endtask

    task automatic add(logic [19:0] p, logic [19:0] t, logic [15:0] h);
        sample_q.push_back({h, t, p});
    endtask

    task automatic add_random(int n);
        logic [19:0] p, t;
        logic [15:0] h;
        repeat (n) begin
            if ($urandom_range(0, 99) < 70) begin
                p = 20'($urandom_range(200000, 600000));
                t = 20'($urandom_range(400000, 620000));
                h = 16'($urandom_range(15000, 45000));
            end else begin
                p = 20'($urandom());
                t = 20'($urandom());
                h = 16'($urandom());
            end
            if ($urandom_range(0, 99) < 5) t = TEMP_OFF_RAW;
            if ($urandom_range(0, 99) < 6) p = PRESS_OFF_RAW;
            if ($urandom_range(0, 99) < 6) h = HUM_OFF_RAW;
            add(p, t, h);
        end
    endtask

    task automatic drain();
        while (sample_q.size() > 0 || s_tvalid || reading_q.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    initial begin
        k_temp = '0; k_plo = '0; k_pmid = '0; k_phi = '0; k_hlo = '0; k_hhi = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        running = 1;

        // reset calibration (all zero)
        add_random(20);
        drain();

        // directed samples with typical coefficients
        load_typical(0, 16'd36477);
        add(20'd415148, 20'd519888, 16'd30000);
        add(20'd0, 20'd0, 16'd0);
        add(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        add(20'd0, 20'hFFFFF, 16'd0);
        add(20'hFFFFF, 20'd0, 16'hFFFF);
        add(PRESS_OFF_RAW, 20'd519888, 16'd30000);
        add(20'd415148, 20'd519888, HUM_OFF_RAW);
        add(PRESS_OFF_RAW, 20'd519888, HUM_OFF_RAW);
        add(20'd415148, TEMP_OFF_RAW, 16'd30000);
        add(PRESS_OFF_RAW, TEMP_OFF_RAW, HUM_OFF_RAW);
        add(20'h7FFFF, 20'h80001, 16'h7FFF);
        add(20'h80001, 20'h7FFFF, 16'h8001);
        add(20'd415148, 20'd300000, 16'd60000);
        add(20'd415148, 20'd800000, 16'd1000);
        add(20'd100, 20'd519888, 16'd65000);
        add(20'd1000000, 20'd519888, 16'd10);
        drain();

        // pressure divisor of zero
        load_typical(0, 16'd0);
        add(20'd415148, 20'd519888, 16'd30000);
        add(20'hFFFFF, 20'd0, 16'd0);
        add_random(30);
        drain();

        // register extremes
        load_cal({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}});
        add_random(40);
        drain();
        load_cal({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h8000}}, {3{16'h7FFF}},
                 48'({8'hFF, 16'h8000, 8'hFF}), 48'({8'h80, 16'h7FFF, 16'h8000}));
        add_random(40);
        drain();

        // random content with varied calibration; the middle phase runs without random gaps or stalls
        for (int ph = 0; ph < 9; ph++) begin
            case (ph % 3)
                0: load_typical(200, jit(36477, 2000));
                1: load_typical(8, 16'd36477);
                default: load_cal(rnd48(), rnd48(), rnd48(), rnd48(), rnd48(), rnd48());
            endcase
            calm = (ph == 4);
            add_random(ph == 2 ? 400 : 70);
            drain();
        end
        calm = 0;

        $display("covered %0d samples, %0d results, %0d register writes",
                 sent, got, cfg_writes);
        $display("including disabled channels, zero divisor and register extremes");
        if (errors == 0) begin
            $display("PASS climate_sensor_compensation");
        end else begin
            $display("FAIL climate_sensor_compensation");
        end
        $finish;
    end
endmodule
